// ===== rtl/hashed_position_cache_top_assert.svh =====
// Assertion macros shared by the hashed position cache modules.
// Included by files that check their own logic; no other dependencies.
`ifndef HASHED_POSITION_CACHE_TOP_ASSERT_SVH
`define HASHED_POSITION_CACHE_TOP_ASSERT_SVH

// Consequence must hold in the same cycle as the condition.
`define HPC_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the condition.
`define HPC_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hpc_pkg.sv =====
// Shared constants, codes and width helpers of the hashed position cache.
// No dependencies.
package hpc_pkg;

    localparam int DEF_TABLE_DEPTH = 65536;
    localparam int DEF_MOVE_BITS   = 16;

    localparam int               CFG_W     = 17;
    localparam logic [CFG_W-1:0] CFG_RESET = 17'h10000;

    localparam logic [1:0] MODE_RECORD = 2'd0;
    localparam logic [1:0] MODE_PROBE  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] FLAG_MASK = 2'h3;

    // remainder unit: key bits consumed per cycle and remainder steps per key
    localparam int DIV_STEP   = 4;
    localparam int DIV_CYCLES = 64 / DIV_STEP;

    typedef enum logic [1:0] {
        KIND_RECORD,
        KIND_PROBE,
        KIND_CLEAR,
        KIND_NONE
    } t_kind;

    function automatic int idx_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // kind, index, key, score, depth, flag, move
    function automatic int cmd_bits(input int iw, input int mb);
        return 2 + iw + 64 + 32 + 8 + 2 + mb;
    endfunction

endpackage

// ===== rtl/hpc_if.sv =====
// Valid/ready channel interfaces of the hashed position cache.
// Depends on nothing; payload widths are fixed by the item format.
interface hpc_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [63:0]        key;
    logic signed [31:0] score;
    logic [7:0]         depth;
    logic [1:0]         bound_flag;
    logic [15:0]        move_in;
    modport source (output valid, mode, key, score, depth, bound_flag, move_in,
                    input ready);
    modport sink (input valid, mode, key, score, depth, bound_flag, move_in,
                  output ready);
endinterface

interface hpc_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic               stored;
    logic signed [31:0] score_out;
    logic [15:0]        move_out;
    logic [7:0]         depth_out;
    logic [1:0]         flag_out;
    modport source (output valid, hit, stored, score_out, move_out, depth_out, flag_out,
                    input ready);
    modport sink (input valid, hit, stored, score_out, move_out, depth_out, flag_out,
                  output ready);
endinterface

interface hpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/hashed_position_cache_top.sv =====
// Hashed position cache: direct-mapped table of search results keyed by a
// 64-bit position key. Channels: i_cmd (items in), o_rsp (one result per
// item), i_cfg (writes entries_in_use, always ready).
// Each accepted item gives exactly one result, in order. A record or probe
// first passes the remainder unit (4 key bits a cycle reduce the key
// modulo the entries in use), then a read of the entry memory and, for a
// record, a read-modify-write of the entry; the front end takes a new item
// only after pushing the last one into the queue. A clear, an unused mode
// or a disabled table skips the remainder unit; a clear then sweeps all
// TABLE_DEPTH entries, one a cycle, after its result is registered. Reset
// sets entries_in_use to 65536 and runs the same sweep; no item is accepted
// until it ends. A stalled receiver holds the result register; the two-entry
// queue lets the front end keep reducing keys until it fills, then the front
// end waits in F_PUSH and i_cmd.ready stays low.
module hashed_position_cache_top #(
    parameter int TABLE_DEPTH = hpc_pkg::DEF_TABLE_DEPTH,
    parameter int MOVE_BITS   = hpc_pkg::DEF_MOVE_BITS
) (
    input logic       i_clk,
    input logic       i_rst_n,
    hpc_cmd_if.sink   i_cmd,
    hpc_rsp_if.source o_rsp,
    hpc_cfg_if.sink   i_cfg
);
    import hpc_pkg::*;

    localparam int IW    = idx_bits(TABLE_DEPTH);
    localparam int CMD_W = cmd_bits(IW, MOVE_BITS);

    logic [CFG_W-1:0] r_entries;
    logic             w_fq_valid;
    logic             w_fq_ready;
    logic [CMD_W-1:0] w_fq_data;
    logic             w_qb_valid;
    logic             w_qb_ready;
    logic [CMD_W-1:0] w_qb_data;
    logic             w_sweeping;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= CFG_RESET;
        end else if (i_cfg.valid) begin
            r_entries <= i_cfg.data;
        end
    end

    hpc_front #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .MOVE_BITS  (MOVE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .i_entries (r_entries),
        .i_sweeping(w_sweeping),
        .o_q_valid (w_fq_valid),
        .i_q_ready (w_fq_ready),
        .o_q_data  (w_fq_data)
    );

    hpc_queue #(
        .WIDTH(CMD_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_fq_valid),
        .o_ready(w_fq_ready),
        .i_data (w_fq_data),
        .o_valid(w_qb_valid),
        .i_ready(w_qb_ready),
        .o_data (w_qb_data)
    );

    hpc_back #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .MOVE_BITS  (MOVE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_qb_valid),
        .o_q_ready (w_qb_ready),
        .i_q_data  (w_qb_data),
        .o_sweeping(w_sweeping),
        .o_rsp     (o_rsp)
    );

endmodule

// ===== rtl/hpc_front.sv =====
// Front end: accepts items, classifies them and reduces the key modulo the
// entries in use with an iterative remainder unit. Uses hpc_pkg, hpc_cmd_if.
module hpc_front #(
    parameter int TABLE_DEPTH = hpc_pkg::DEF_TABLE_DEPTH,
    parameter int MOVE_BITS   = hpc_pkg::DEF_MOVE_BITS,
    localparam int IW    = hpc_pkg::idx_bits(TABLE_DEPTH),
    localparam int CMD_W = hpc_pkg::cmd_bits(IW, MOVE_BITS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    hpc_cmd_if.sink                  i_cmd,
    input  logic [hpc_pkg::CFG_W-1:0] i_entries,
    input  logic                     i_sweeping,
    output logic                     o_q_valid,
    input  logic                     i_q_ready,
    output logic [CMD_W-1:0]         o_q_data
);
    import hpc_pkg::*;

    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = $clog2(DIV_CYCLES);

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} t_fstate;

    typedef struct packed {
        t_kind                 kind;
        logic [IW-1:0]         idx;
        logic [63:0]           key;
        logic [31:0]           score;
        logic [7:0]            depth;
        logic [1:0]            flag;
        logic [MOVE_BITS-1:0]  move;
    } t_cmd;

    t_fstate         r_state;
    t_kind           r_kind;
    logic [63:0]     r_key;
    logic [63:0]     r_sh;
    logic [31:0]     r_score;
    logic [7:0]      r_depth;
    logic [1:0]      r_flag;
    logic [MOVE_BITS-1:0] r_move;
    logic [NW-1:0]   r_n;
    logic [NW-1:0]   r_rem;
    logic [CW-1:0]   r_cnt;

    logic [NW-1:0]   n_rem;
    logic [NW-1:0]   w_n_eff;
    t_kind           w_kind;
    logic            w_accept;
    t_cmd            w_cmd;

    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == F_IDLE) && !i_sweeping;

    always_comb begin
        if (32'(i_entries) > 32'(TABLE_DEPTH)) begin
            w_n_eff = NW'(TABLE_DEPTH);
        end else begin
            w_n_eff = NW'(i_entries);
        end
    end

    always_comb begin
        case (i_cmd.mode)
            MODE_RECORD: w_kind = KIND_RECORD;
            MODE_PROBE:  w_kind = KIND_PROBE;
            MODE_CLEAR:  w_kind = KIND_CLEAR;
            default:     w_kind = KIND_NONE;
        endcase
        // a disabled table turns record and probe into a no-op
        if (w_n_eff == '0 && (w_kind == KIND_RECORD || w_kind == KIND_PROBE)) begin
            w_kind = KIND_NONE;
        end
    end

    // restoring remainder, DIV_STEP key bits per cycle, MSB first
    always_comb begin
        logic [NW:0]   u;
        logic [NW-1:0] t;
        t = r_rem;
        for (int j = 0; j < DIV_STEP; j++) begin
            u = {t, r_sh[63-j]};
            if (u >= {1'b0, r_n}) begin
                u = u - {1'b0, r_n};
            end
            t = u[NW-1:0];
        end
        n_rem = t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_kind  <= KIND_NONE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (w_accept) begin
                        r_kind  <= w_kind;
                        r_key   <= i_cmd.key;
                        r_sh    <= i_cmd.key;
                        r_score <= i_cmd.score;
                        r_depth <= i_cmd.depth;
                        r_flag  <= i_cmd.bound_flag & FLAG_MASK;
                        r_move  <= MOVE_BITS'(i_cmd.move_in);
                        r_n     <= w_n_eff;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        if (w_kind == KIND_RECORD || w_kind == KIND_PROBE) begin
                            r_state <= F_DIV;
                        end else begin
                            r_state <= F_PUSH;
                        end
                    end
                end
                F_DIV: begin
                    r_rem <= n_rem;
                    r_sh  <= r_sh << DIV_STEP;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(DIV_CYCLES - 1)) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (i_q_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_comb begin
        w_cmd.kind  = r_kind;
        w_cmd.idx   = (r_kind == KIND_RECORD || r_kind == KIND_PROBE) ? r_rem[IW-1:0] : '0;
        w_cmd.key   = r_key;
        w_cmd.score = r_score;
        w_cmd.depth = r_depth;
        w_cmd.flag  = r_flag;
        w_cmd.move  = r_move;
    end

    assign o_q_valid = (r_state == F_PUSH);
    assign o_q_data  = w_cmd;

`include "hashed_position_cache_top_assert.svh"

    `HPC_ASSERT_NOW(a_index_in_range, i_clk, i_rst_n,
        r_state == F_PUSH && (r_kind == KIND_RECORD || r_kind == KIND_PROBE),
        r_rem < r_n, "index not below entries in use")
    `HPC_ASSERT_NOW(a_no_accept_in_sweep, i_clk, i_rst_n, i_sweeping,
        r_state != F_IDLE || !w_accept, "item accepted during table sweep")
    `HPC_ASSERT_NEXT(a_push_holds, i_clk, i_rst_n, o_q_valid && !i_q_ready,
        o_q_valid, "queue beat dropped while stalled")

endmodule

// ===== rtl/hpc_queue.sv =====
// Two-entry queue between the front end and the table engine.
// Depends on nothing.
module hpc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_q [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_q[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/hpc_back.sv =====
// Table engine: entry memory, read-modify-write of records, probes, clearing
// sweep and the result register. Uses hpc_pkg and hpc_rsp_if.
module hpc_back #(
    parameter int TABLE_DEPTH = hpc_pkg::DEF_TABLE_DEPTH,
    parameter int MOVE_BITS   = hpc_pkg::DEF_MOVE_BITS,
    localparam int IW    = hpc_pkg::idx_bits(TABLE_DEPTH),
    localparam int CMD_W = hpc_pkg::cmd_bits(IW, MOVE_BITS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_q_ready,
    input  logic [CMD_W-1:0] i_q_data,
    output logic             o_sweeping,
    hpc_rsp_if.source        o_rsp
);
    import hpc_pkg::*;

    typedef enum logic [1:0] {B_SWEEP, B_IDLE, B_READ, B_EXEC} t_bstate;

    typedef struct packed {
        t_kind                 kind;
        logic [IW-1:0]         idx;
        logic [63:0]           key;
        logic [31:0]           score;
        logic [7:0]            depth;
        logic [1:0]            flag;
        logic [MOVE_BITS-1:0]  move;
    } t_cmd;

    typedef struct packed {
        logic [63:0]           key;
        logic                  occ;
        logic [31:0]           score;
        logic [MOVE_BITS-1:0]  move;
        logic [7:0]            depth;
        logic [1:0]            flag;
    } t_entry;

    t_entry  r_mem [TABLE_DEPTH];
    t_entry  r_rd;
    t_cmd    r_cmd;
    t_bstate r_state;
    logic [IW-1:0] r_addr;

    logic               r_out_valid;
    logic               r_hit;
    logic               r_stored;
    logic signed [31:0] r_score;
    logic [15:0]        r_move;
    logic [7:0]         r_depth;
    logic [1:0]         r_flag;

    logic          w_same;
    logic          w_skip;
    logic          w_out_free;
    logic          w_we;
    logic [IW-1:0] w_wa;
    t_entry        w_wd;
    logic          w_hit;
    logic          w_stored;

    assign w_same     = r_rd.occ && (r_rd.key == r_cmd.key);
    assign w_skip     = r_rd.occ && !w_same && (r_cmd.depth < r_rd.depth);
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_hit      = (r_cmd.kind == KIND_PROBE) && w_same;
    assign w_stored   = (r_cmd.kind == KIND_RECORD) && !w_skip;

    always_comb begin
        w_we = 1'b0;
        w_wa = r_addr;
        w_wd = '0;
        if (r_state == B_SWEEP) begin
            w_we = 1'b1;
        end else if (r_state == B_EXEC && w_out_free && w_stored) begin
            w_we       = 1'b1;
            w_wa       = r_cmd.idx;
            w_wd.key   = r_cmd.key;
            w_wd.occ   = 1'b1;
            w_wd.score = r_cmd.score;
            // keep the stored move when the same key comes without one
            w_wd.move  = (r_cmd.move == '0 && w_same) ? r_rd.move : r_cmd.move;
            w_wd.depth = r_cmd.depth;
            w_wd.flag  = r_cmd.flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[r_cmd.idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_SWEEP;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
            r_cmd.kind  <= KIND_NONE;
            r_cmd.idx   <= '0;
        end else begin
            // drop the result once taken, unless a new one loads this cycle
            if (r_out_valid && o_rsp.ready && !(r_state == B_EXEC && w_out_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_SWEEP: begin
                    if (r_addr == IW'(TABLE_DEPTH - 1)) begin
                        r_addr  <= '0;
                        r_state <= B_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd   <= i_q_data;
                        r_state <= B_READ;
                    end
                end
                B_READ: r_state <= B_EXEC;
                B_EXEC: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_hit       <= w_hit;
                        r_stored    <= w_stored;
                        r_score     <= w_hit ? $signed(r_rd.score) : '0;
                        r_move      <= w_hit ? r_rd.move[15:0] : '0;
                        r_depth     <= w_hit ? r_rd.depth : '0;
                        r_flag      <= w_hit ? r_rd.flag : '0;
                        r_state     <= (r_cmd.kind == KIND_CLEAR) ? B_SWEEP : B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_q_ready       = (r_state == B_IDLE);
    assign o_sweeping      = (r_state == B_SWEEP);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.hit       = r_hit;
    assign o_rsp.stored    = r_stored;
    assign o_rsp.score_out = r_score;
    assign o_rsp.move_out  = r_move;
    assign o_rsp.depth_out = r_depth;
    assign o_rsp.flag_out  = r_flag;

`include "hashed_position_cache_top_assert.svh"

    `HPC_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, r_out_valid && !r_hit,
        r_score == '0 && r_move == '0 && r_depth == '0 && r_flag == '0,
        "miss result carries nonzero fields")
    `HPC_ASSERT_NOW(a_hit_xor_stored, i_clk, i_rst_n, r_out_valid,
        !(r_hit && r_stored), "result both hit and stored")
    `HPC_ASSERT_NEXT(a_clear_sweeps, i_clk, i_rst_n,
        r_state == B_EXEC && w_out_free && r_cmd.kind == KIND_CLEAR,
        r_state == B_SWEEP && r_addr == '0, "clear did not start a sweep")

endmodule
